[rtl/core/pmc_pkg.sv]
// Shared constants, types and helper functions of the procedural motion curve block.
package pmc_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int T_W          = FRAC_BITS + 1;
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
   localparam int OP_W         = 34;
   localparam int PROD_W       = 2 * OP_W;
   localparam int ACC_W        = 36;
   localparam int CSR_IDX_W    = 3;

   localparam logic [T_W-1:0]         T_ONE       = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [30:0]            DUR_RESET   = 31'(T_ONE);
   localparam logic signed [OP_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [OP_W-1:0] INV_TWO_PI  = 34'sd683565276;
   localparam int                     CORDIC_Q    = 30;

   // Position modes.
   localparam logic [1:0] MODE_PARABOLA = 2'd1;
   localparam logic [1:0] MODE_ORBIT    = 2'd2;

   // End actions.
   localparam logic [1:0] END_HOLD       = 2'd0;
   localparam logic [1:0] END_RESTART    = 2'd1;
   localparam logic [1:0] END_TRANSITION = 2'd2;
   localparam logic [1:0] END_REMOVAL    = 2'd3;

   // End event codes.
   localparam logic [2:0] EV_RUNNING    = 3'd0;
   localparam logic [2:0] EV_HELD       = 3'd1;
   localparam logic [2:0] EV_RESTARTED  = 3'd2;
   localparam logic [2:0] EV_TRANSITION = 3'd3;
   localparam logic [2:0] EV_REMOVAL    = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_A  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_B  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_P_T2,
      ST_P_BX,
      ST_P_AX,
      ST_P_BY,
      ST_P_AY,
      ST_P_FIN,
      ST_O_PHI,
      ST_O_TURN,
      ST_O_FOLD,
      ST_O_CORDIC,
      ST_O_RX,
      ST_O_RY,
      ST_O_FIN,
      ST_R_MUL,
      ST_R_FIN,
      ST_DONE
   } state_type;

   function automatic logic signed [OP_W-1:0] sext34(input logic [31:0] v);
      return {{(OP_W-32){v[31]}}, v};
   endfunction

   function automatic logic signed [ACC_W-1:0] sext36(input logic [31:0] v);
      return {{(ACC_W-32){v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Arctangent of 2^-i as a fraction of a full turn, scaled by 2^32.
   function automatic logic signed [OP_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [OP_W-1:0] r;
      case (idx)
         5'd0:    r = 34'sh020000000;
         5'd1:    r = 34'sh012E4051D;
         5'd2:    r = 34'sh009FB385B;
         5'd3:    r = 34'sh0051111D4;
         5'd4:    r = 34'sh0028B0D43;
         5'd5:    r = 34'sh00145D7E1;
         5'd6:    r = 34'sh000A2F61E;
         5'd7:    r = 34'sh000517C55;
         5'd8:    r = 34'sh00028BE53;
         5'd9:    r = 34'sh000145F2F;
         5'd10:   r = 34'sh0000A2F98;
         5'd11:   r = 34'sh0000517CC;
         5'd12:   r = 34'sh000028BE6;
         5'd13:   r = 34'sh0000145F3;
         5'd14:   r = 34'sh000000A2F9;
         5'd15:   r = 34'sh00000517C;
         5'd16:   r = 34'sh0000028BE;
         5'd17:   r = 34'sh00000145F;
         5'd18:   r = 34'sh000000A2F;
         5'd19:   r = 34'sh000000517;
         5'd20:   r = 34'sh00000028B;
         5'd21:   r = 34'sh000000145;
         5'd22:   r = 34'sh0000000A2;
         5'd23:   r = 34'sh000000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/pmc_mul.sv]
// Shared signed multiplier with a registered product.
module pmc_mul (
   input  logic                                   clock,
   input  logic signed [pmc_pkg::OP_W-1:0]        mul_a,
   input  logic signed [pmc_pkg::OP_W-1:0]        mul_b,
   output logic signed [pmc_pkg::PROD_W-1:0]      mul_p
);

   logic signed [pmc_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;

endmodule

[rtl/core/pmc_div.sv]
// Restoring divider giving the phase elapsed/duration, one quotient bit per cycle.
module pmc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [30:0]                 dividend,
   input  logic [30:0]                 divisor,
   output logic [pmc_pkg::T_W-1:0]     quot,
   output logic                        done
);

   localparam int CNT_W = $clog2(pmc_pkg::FRAC_BITS);

   logic [31:0]              rem_ff, rem_in;
   logic [pmc_pkg::T_W-1:0]  q_ff, q_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [31:0]              trial;
   logic [32:0]              diff;
   logic                     q_bit;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // The dividend never exceeds the divisor, so the first step yields the
      // integer bit and the remainder then stays below the divisor.
      trial = start ? {1'b0, dividend} : {rem_ff[30:0], 1'b0};
      diff  = {1'b0, trial} - {2'b00, divisor};
      q_bit = ~diff[32];
      if (start) begin
         rem_in  = q_bit ? diff[31:0] : trial;
         q_in    = {{(pmc_pkg::T_W-1){1'b0}}, q_bit};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = q_bit ? diff[31:0] : trial;
         q_in   = {q_ff[pmc_pkg::T_W-2:0], q_bit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(pmc_pkg::FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign quot = q_ff;
   assign done = done_ff;

endmodule

[rtl/core/pmc_cordic.sv]
// Iterative rotation-mode CORDIC giving cosine and sine in Q4.30 of a binary angle.
module pmc_cordic #(
   parameter int STEPS = pmc_pkg::CORDIC_STEPS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [31:0]                        phase,
   output logic signed [pmc_pkg::OP_W-1:0]    cos_out,
   output logic signed [pmc_pkg::OP_W-1:0]    sin_out,
   output logic                               done
);

   localparam int IW = pmc_pkg::ATAN_IDX_W;

   logic signed [pmc_pkg::OP_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [pmc_pkg::OP_W-1:0] z0, dx, dy, at;
   logic [IW-1:0]                   i_ff, i_in;
   logic                            neg_ff, neg_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      z0 = pmc_pkg::sext34(phase);
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      at = pmc_pkg::atan_turn(i_ff);
      if (start) begin
         // Fold the angle into [-90, 90] degrees; the results are negated later.
         neg_in = 1'b0;
         z_in   = z0;
         if (z0 > 34'sh040000000) begin
            z_in   = z0 - 34'sh080000000;
            neg_in = 1'b1;
         end else if (z0 < -34'sh040000000) begin
            z_in   = z0 + 34'sh080000000;
            neg_in = 1'b1;
         end
         x_in    = pmc_pkg::CORDIC_GAIN;
         y_in    = '0;
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[pmc_pkg::OP_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == IW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;
   assign done    = done_ff;

endmodule

[rtl/core/procedural_motion_curve_step.sv]
// Top level: tick sequencer, registers and result stage of the motion curve block.
// The time from the accepting edge to rsp_valid depends on the position mode: none, parabola,
// or orbit with its CORDIC loop; a zero duration skips the phase divider. A new item is
// accepted no earlier than the cycle after the previous result is loaded into the output
// register, so the time per item is set by the phase divider, the CORDIC loop and the
// single shared multiplier. Reset is synchronous and active high; it restores the register
// reset values and zero elapsed time.
module procedural_motion_curve_step #(
   parameter int CORDIC_STEPS = pmc_pkg::CORDIC_STEPS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [31:0]                  req_time_step,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_offset_x,
   output logic signed [31:0]                  rsp_offset_y,
   output logic                                rsp_offset_valid,
   output logic signed [31:0]                  rsp_angle_out,
   output logic                                rsp_angle_valid,
   output logic [2:0]                          rsp_end_event,
   input  logic                                csr_write_en,
   input  logic [pmc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [63:0]                         csr_wdata
);

   localparam int FB  = pmc_pkg::FRAC_BITS;
   localparam int OW  = pmc_pkg::OP_W;
   localparam int AW  = pmc_pkg::ACC_W;
   localparam int TW  = pmc_pkg::T_W;

   pmc_pkg::state_type state_ff, state_in;

   logic [4:0]   ctrl_ff;
   logic [30:0]  dur_ff;
   logic [63:0]  start_ff, cva_ff, cvb_ff, rot_ff;
   logic [30:0]  elapsed_ff;
   logic [2:0]   ev_ff;
   logic [TW-1:0] t_ff, t2_ff;
   logic signed [AW-1:0] accx_ff, accy_ff;
   logic signed [31:0] ang_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_ang_ff;
   logic               rsp_ov_ff, rsp_av_ff;
   logic [2:0]         rsp_ev_ff;

   logic                 accept, out_free, dur_zero, at_end, pos_on;
   logic [1:0]           mode, action;
   logic signed [33:0]   e_sum;
   logic [30:0]          e_clamp;
   logic [2:0]           ev_new;
   logic signed [OW-1:0] mul_a, mul_b;
   logic signed [pmc_pkg::PROD_W-1:0] mul_p;
   logic signed [OW-1:0] bx, by, rdiff, t_op, t2_op, phi_op, cos_v, sin_v;
   logic signed [AW-1:0] sh16, sh30;
   logic [31:0]          turns;
   logic                 div_start, div_done, cor_start, cor_done;
   logic [TW-1:0]        div_quot;

   assign mode     = ctrl_ff[1:0];
   assign action   = ctrl_ff[4:3];
   assign dur_zero = (dur_ff == '0);
   assign pos_on   = (mode == pmc_pkg::MODE_PARABOLA) || (mode == pmc_pkg::MODE_ORBIT);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // Elapsed time plus this tick, clamped to [0, duration].
   always_comb begin
      e_sum = $signed({3'b000, elapsed_ff}) + {{2{req_time_step[31]}}, req_time_step};
      if (e_sum[33]) begin
         e_clamp = '0;
      end else if (e_sum[32:0] > {2'b00, dur_ff}) begin
         e_clamp = dur_ff;
      end else begin
         e_clamp = e_sum[30:0];
      end
      at_end = (e_clamp == dur_ff);
      ev_new = pmc_pkg::EV_RUNNING;
      if (at_end) begin
         case (action)
            pmc_pkg::END_HOLD:       ev_new = pmc_pkg::EV_HELD;
            pmc_pkg::END_RESTART:    ev_new = pmc_pkg::EV_RESTARTED;
            pmc_pkg::END_TRANSITION: ev_new = pmc_pkg::EV_TRANSITION;
            default:                 ev_new = pmc_pkg::EV_REMOVAL;
         endcase
      end
   end

   assign bx     = pmc_pkg::sext34(cvb_ff[31:0]) - pmc_pkg::sext34(start_ff[31:0])
                   - pmc_pkg::sext34(cva_ff[31:0]);
   assign by     = pmc_pkg::sext34(cvb_ff[63:32]) - pmc_pkg::sext34(start_ff[63:32])
                   - pmc_pkg::sext34(cva_ff[63:32]);
   assign rdiff  = pmc_pkg::sext34(rot_ff[63:32]) - pmc_pkg::sext34(rot_ff[31:0]);
   assign t_op   = {{(OW-TW){1'b0}}, t_ff};
   assign t2_op  = {{(OW-TW){1'b0}}, t2_ff};
   assign phi_op = $signed(mul_p[FB +: OW]);
   assign sh16   = $signed(mul_p[FB +: AW]);
   assign sh30   = $signed(mul_p[pmc_pkg::CORDIC_Q +: AW]);
   assign turns  = mul_p[FB +: 32];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pmc_pkg::ST_IDLE:     if (accept) state_in = pmc_pkg::ST_DIV;
         pmc_pkg::ST_DIV: begin
            if (dur_zero || div_done) begin
               if (mode == pmc_pkg::MODE_PARABOLA) begin
                  state_in = pmc_pkg::ST_P_T2;
               end else if (mode == pmc_pkg::MODE_ORBIT) begin
                  state_in = pmc_pkg::ST_O_PHI;
               end else begin
                  state_in = pmc_pkg::ST_R_MUL;
               end
            end
         end
         pmc_pkg::ST_P_T2:     state_in = pmc_pkg::ST_P_BX;
         pmc_pkg::ST_P_BX:     state_in = pmc_pkg::ST_P_AX;
         pmc_pkg::ST_P_AX:     state_in = pmc_pkg::ST_P_BY;
         pmc_pkg::ST_P_BY:     state_in = pmc_pkg::ST_P_AY;
         pmc_pkg::ST_P_AY:     state_in = pmc_pkg::ST_P_FIN;
         pmc_pkg::ST_P_FIN:    state_in = pmc_pkg::ST_R_MUL;
         pmc_pkg::ST_O_PHI:    state_in = pmc_pkg::ST_O_TURN;
         pmc_pkg::ST_O_TURN:   state_in = pmc_pkg::ST_O_FOLD;
         pmc_pkg::ST_O_FOLD:   state_in = pmc_pkg::ST_O_CORDIC;
         pmc_pkg::ST_O_CORDIC: if (cor_done) state_in = pmc_pkg::ST_O_RX;
         pmc_pkg::ST_O_RX:     state_in = pmc_pkg::ST_O_RY;
         pmc_pkg::ST_O_RY:     state_in = pmc_pkg::ST_O_FIN;
         pmc_pkg::ST_O_FIN:    state_in = pmc_pkg::ST_R_MUL;
         pmc_pkg::ST_R_MUL:    state_in = pmc_pkg::ST_R_FIN;
         pmc_pkg::ST_R_FIN:    state_in = pmc_pkg::ST_DONE;
         pmc_pkg::ST_DONE:     if (out_free) state_in = pmc_pkg::ST_IDLE;
         default:              state_in = pmc_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: request ready, multiplier operands and unit starts.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      cor_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         pmc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            div_start = req_valid && !dur_zero;
         end
         pmc_pkg::ST_P_T2: begin
            mul_a = t_op;
            mul_b = t_op;
         end
         pmc_pkg::ST_P_BX: begin
            mul_a = bx;
            mul_b = t_op;
         end
         pmc_pkg::ST_P_AX: begin
            mul_a = pmc_pkg::sext34(cva_ff[31:0]);
            mul_b = t2_op;
         end
         pmc_pkg::ST_P_BY: begin
            mul_a = by;
            mul_b = t_op;
         end
         pmc_pkg::ST_P_AY: begin
            mul_a = pmc_pkg::sext34(cva_ff[63:32]);
            mul_b = t2_op;
         end
         pmc_pkg::ST_O_PHI: begin
            mul_a = pmc_pkg::sext34(cva_ff[63:32]);
            mul_b = t_op;
         end
         pmc_pkg::ST_O_TURN: begin
            mul_a = phi_op;
            mul_b = pmc_pkg::INV_TWO_PI;
         end
         pmc_pkg::ST_O_FOLD:   cor_start = 1'b1;
         pmc_pkg::ST_O_RX: begin
            mul_a = pmc_pkg::sext34(cva_ff[31:0]);
            mul_b = cos_v;
         end
         pmc_pkg::ST_O_RY: begin
            mul_a = pmc_pkg::sext34(cva_ff[31:0]);
            mul_b = sin_v;
         end
         pmc_pkg::ST_R_MUL: begin
            mul_a = rdiff;
            mul_b = t_op;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmc_pkg::ST_IDLE;
         ctrl_ff      <= '0;
         dur_ff       <= pmc_pkg::DUR_RESET;
         start_ff     <= '0;
         cva_ff       <= '0;
         cvb_ff       <= '0;
         rot_ff       <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            unique case (csr_index)
               pmc_pkg::CSR_CONTROL:  ctrl_ff  <= csr_wdata[4:0];
               pmc_pkg::CSR_DURATION: dur_ff   <= csr_wdata[30:0];
               pmc_pkg::CSR_START:    start_ff <= csr_wdata;
               pmc_pkg::CSR_CURVE_A:  cva_ff   <= csr_wdata;
               pmc_pkg::CSR_CURVE_B:  cvb_ff   <= csr_wdata;
               pmc_pkg::CSR_ROTATION: rot_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         // A restart clears the elapsed time, but this item still uses the end phase.
         if (accept) begin
            elapsed_ff <= (at_end && action == pmc_pkg::END_RESTART) ? '0 : e_clamp;
         end
         if (state_ff == pmc_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         ev_ff <= ev_new;
      end
      if (state_ff == pmc_pkg::ST_DIV) begin
         t_ff <= dur_zero ? pmc_pkg::T_ONE : div_quot;
      end
      unique case (state_ff)
         pmc_pkg::ST_P_BX:  t2_ff   <= mul_p[FB +: TW];
         pmc_pkg::ST_P_AX:  accx_ff <= pmc_pkg::sext36(start_ff[31:0]) + sh16;
         pmc_pkg::ST_P_BY:  accx_ff <= accx_ff + sh16;
         pmc_pkg::ST_P_AY:  accy_ff <= pmc_pkg::sext36(start_ff[63:32]) + sh16;
         pmc_pkg::ST_P_FIN: accy_ff <= accy_ff + sh16;
         pmc_pkg::ST_O_RY:  accx_ff <= pmc_pkg::sext36(start_ff[31:0]) + sh30;
         pmc_pkg::ST_O_FIN: accy_ff <= pmc_pkg::sext36(start_ff[63:32]) + sh30;
         pmc_pkg::ST_R_FIN: ang_ff  <= pmc_pkg::sat32(pmc_pkg::sext36(rot_ff[31:0]) + sh16);
         default: begin
         end
      endcase
      if (state_ff == pmc_pkg::ST_DONE && out_free) begin
         rsp_ov_ff  <= pos_on;
         rsp_x_ff   <= pos_on ? pmc_pkg::sat32(accx_ff) : '0;
         rsp_y_ff   <= pos_on ? pmc_pkg::sat32(accy_ff) : '0;
         rsp_av_ff  <= ctrl_ff[2];
         rsp_ang_ff <= ctrl_ff[2] ? ang_ff : '0;
         rsp_ev_ff  <= ev_ff;
      end
   end

   pmc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   pmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (e_clamp),
      .divisor  (dur_ff),
      .quot     (div_quot),
      .done     (div_done)
   );

   pmc_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .phase   (turns),
      .cos_out (cos_v),
      .sin_out (sin_v),
      .done    (cor_done)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_offset_x     = rsp_x_ff;
   assign rsp_offset_y     = rsp_y_ff;
   assign rsp_offset_valid = rsp_ov_ff;
   assign rsp_angle_out    = rsp_ang_ff;
   assign rsp_angle_valid  = rsp_av_ff;
   assign rsp_end_event    = rsp_ev_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == pmc_pkg::ST_DIV)
      else $error("accepted item did not start the phase division");

   a_div_done_place: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == pmc_pkg::ST_DIV)
      else $error("divider finished outside the division state");

   a_cordic_done_place: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> state_ff == pmc_pkg::ST_O_CORDIC)
      else $error("CORDIC finished outside its wait state");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pmc_pkg::ST_DONE && out_free) |=> rsp_valid_ff && req_ready)
      else $error("finished item was not moved to the output register");

endmodule

[sim/procedural_motion_curve_step_tb.sv]
// Self-checking testbench of the procedural motion curve block, with a built-in predictor.
module procedural_motion_curve_step_tb;

   typedef struct packed {
      logic signed [31:0] off_x;
      logic signed [31:0] off_y;
      logic               off_v;
      logic signed [31:0] ang;
      logic               ang_v;
      logic [2:0]         ev;
   } motion_type;

   localparam longint LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_time_step = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_offset_x, rsp_offset_y, rsp_angle_out;
   logic rsp_offset_valid, rsp_angle_valid;
   logic [2:0] rsp_end_event;
   logic csr_write_en = 1'b0;
   logic [pmc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   procedural_motion_curve_step dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state and register copies.
   logic [4:0]  m_control;
   logic [30:0] m_duration;
   logic [63:0] m_start, m_curve_a, m_curve_b, m_rotation;
   logic [31:0] m_elapsed;

   logic signed [31:0] step_queue[$];
   motion_type         motion_queue[$];
   int  errors = 0;
   int  stall_hold = 0;
   bit  stimulus_done = 0;
   longint cycles = 0;

   function automatic longint sx(input logic [31:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic logic [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic longint atan_entry(input int i);
      longint tab[24] = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
         64'h00145F2F, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
         64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F,
         64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
      return tab[i];
   endfunction

   function automatic void rotate_unit(input logic [31:0] phase, output longint c,
                                       output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = sx(phase);
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 64'sh40000000) begin
         z -= 64'sh80000000;
         flip = 1;
      end else if (z < -64'sh40000000) begin
         z += 64'sh80000000;
         flip = 1;
      end
      for (int i = 0; i < pmc_pkg::CORDIC_STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_entry(i);
         end else begin
            x += dx; y -= dy; z += atan_entry(i);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic motion_type advance_motion(input logic signed [31:0] step);
      motion_type r;
      longint e, t, stx, sty, ax, ay, bx, by, t2, rad, tot, phi, turns, c, s, r0, r1;
      logic [1:0] mode, action;
      r = '0;
      mode = m_control[1:0];
      action = m_control[4:3];
      stx = sx(m_start[31:0]);
      sty = sx(m_start[63:32]);
      e = longint'(m_elapsed) + longint'(step);
      if (e < 0) e = 0;
      if (e > longint'(m_duration)) e = m_duration;
      m_elapsed = e[31:0];
      if (m_duration == 0) t = 64'd1 << pmc_pkg::FRAC_BITS;
      else t = (longint'(m_elapsed) << pmc_pkg::FRAC_BITS) / longint'(m_duration);
      if (mode == pmc_pkg::MODE_PARABOLA) begin
         ax = sx(m_curve_a[31:0]);
         ay = sx(m_curve_a[63:32]);
         bx = sx(m_curve_b[31:0]) - stx - ax;
         by = sx(m_curve_b[63:32]) - sty - ay;
         t2 = (t * t) >>> pmc_pkg::FRAC_BITS;
         r.off_x = clip32(floor_shift(ax * t2, pmc_pkg::FRAC_BITS)
                          + floor_shift(bx * t, pmc_pkg::FRAC_BITS) + stx);
         r.off_y = clip32(floor_shift(ay * t2, pmc_pkg::FRAC_BITS)
                          + floor_shift(by * t, pmc_pkg::FRAC_BITS) + sty);
         r.off_v = 1'b1;
      end else if (mode == pmc_pkg::MODE_ORBIT) begin
         rad = sx(m_curve_a[31:0]);
         tot = sx(m_curve_a[63:32]);
         phi = floor_shift(tot * t, pmc_pkg::FRAC_BITS);
         turns = floor_shift(phi * 64'sd683565276, pmc_pkg::FRAC_BITS);
         rotate_unit(turns[31:0], c, s);
         r.off_x = clip32(stx + floor_shift(rad * c, 30));
         r.off_y = clip32(sty + floor_shift(rad * s, 30));
         r.off_v = 1'b1;
      end
      if (m_control[2]) begin
         r0 = sx(m_rotation[31:0]);
         r1 = sx(m_rotation[63:32]);
         r.ang = clip32(r0 + floor_shift((r1 - r0) * t, pmc_pkg::FRAC_BITS));
         r.ang_v = 1'b1;
      end
      if (m_elapsed >= m_duration) begin
         r.ev = {1'b0, action} + 3'd1;
         if (action == pmc_pkg::END_RESTART) m_elapsed = '0;
      end
      return r;
   endfunction

   // Driver: one item offered at a time, with random gaps.
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            motion_queue.push_back(advance_motion(req_time_step));
            send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                   : $urandom_range(0, 2);
            if (send_gap == 0 && step_queue.size() > 0) begin
               req_time_step <= step_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (send_gap > 0) send_gap--;
            else if (step_queue.size() > 0) begin
               req_time_step <= step_queue.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Receiver: holds off now and then, counting long stretches in cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (stall_hold > 0) begin
            stall_hold--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 39) == 0) begin
            stall_hold = $urandom_range(20, 150);
            rsp_ready <= 1'b0;
         end else if (stimulus_done || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
         end
      end
   end

   // Monitor: compares every result item with the oldest prediction.
   always @(posedge clock) begin
      motion_type got, want;
      cycles++;
      if (cycles > LIMIT) begin
         $display("procedural_motion_curve_step_tb: done, errors");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_offset_x, rsp_offset_y, rsp_offset_valid, rsp_angle_out,
                    rsp_angle_valid, rsp_end_event};
            if (motion_queue.size() == 0) begin
               $display("%0t: result item with none expected: %p", $time, got);
               errors++;
            end else begin
               want = motion_queue.pop_front();
               if (got.off_x !== want.off_x) begin
                  $display("%0t: offset_x exp %0d got %0d", $time, want.off_x, got.off_x);
                  errors++;
               end
               if (got.off_y !== want.off_y) begin
                  $display("%0t: offset_y exp %0d got %0d", $time, want.off_y, got.off_y);
                  errors++;
               end
               if (got.off_v !== want.off_v) begin
                  $display("%0t: offset_valid exp %0b got %0b", $time, want.off_v, got.off_v);
                  errors++;
               end
               if (got.ang !== want.ang) begin
                  $display("%0t: angle_out exp %0d got %0d", $time, want.ang, got.ang);
                  errors++;
               end
               if (got.ang_v !== want.ang_v) begin
                  $display("%0t: angle_valid exp %0b got %0b", $time, want.ang_v, got.ang_v);
                  errors++;
               end
               if (got.ev !== want.ev) begin
                  $display("%0t: end_event exp %0d got %0d", $time, want.ev, got.ev);
                  errors++;
               end
            end
         end
      end
   end

   task automatic write_reg(input logic [pmc_pkg::CSR_IDX_W-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         pmc_pkg::CSR_CONTROL:  m_control = val[4:0];
         pmc_pkg::CSR_DURATION: m_duration = val[30:0];
         pmc_pkg::CSR_START:    m_start = val;
         pmc_pkg::CSR_CURVE_A:  m_curve_a = val;
         pmc_pkg::CSR_CURVE_B:  m_curve_b = val;
         pmc_pkg::CSR_ROTATION: m_rotation = val;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Waits until every offered item has been answered.
   task automatic drain;
      while (step_queue.size() > 0 || req_valid || motion_queue.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] random_step(input logic [30:0] dur);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return -$urandom_range(0, 70000);
         2: return 32'h7FFFFFFF;
         3: return 32'h80000000;
         default: return (dur == 0) ? $urandom_range(0, 100)
                                    : $urandom_range(0, dur / 4 + 1);
      endcase
   endfunction

   function automatic logic [63:0] random_pair;
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return {32'(($urandom_range(0, 40000) - 20000) * 16),
                    32'(($urandom_range(0, 40000) - 20000) * 16)};
         2: return {32'h7FFFFFFF, 32'h80000000};
         default: return {32'(signed'($urandom_range(0, 2000)) - 1000) <<< 12,
                          32'(signed'($urandom_range(0, 2000)) - 1000) <<< 12};
      endcase
   endfunction

   function automatic logic [30:0] random_duration;
      case ($urandom_range(0, 5))
         0: return 31'd0;
         1: return 31'h7FFFFFFF;
         2: return 31'($urandom_range(1, 8));
         default: return 31'($urandom_range(65536, 65536 * 20));
      endcase
   endfunction

   initial begin
      m_control = '0;
      m_duration = pmc_pkg::DUR_RESET;
      m_start = '0;
      m_curve_a = '0;
      m_curve_b = '0;
      m_rotation = '0;
      m_elapsed = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: parabola, orbit, no position, rotation, every end action, step extremes.
      write_reg(pmc_pkg::CSR_START, {32'sd65536, -32'sd131072});
      write_reg(pmc_pkg::CSR_CURVE_A, {32'sd327680, 32'sd196608});
      write_reg(pmc_pkg::CSR_CURVE_B, {-32'sd65536, 32'sd655360});
      write_reg(pmc_pkg::CSR_ROTATION, {32'sd205887, -32'sd102943});
      write_reg(pmc_pkg::CSR_DURATION, 64'd65536);
      write_reg(pmc_pkg::CSR_CONTROL, {pmc_pkg::END_HOLD, 1'b1, pmc_pkg::MODE_PARABOLA});
      step_queue = '{32'sd0, 32'sd16384, 32'sd16384, 32'sh80000000, 32'sh7FFFFFFF,
                     32'sd100, -32'sd1};
      drain();
      write_reg(pmc_pkg::CSR_CONTROL, {pmc_pkg::END_RESTART, 1'b1, pmc_pkg::MODE_ORBIT});
      write_reg(pmc_pkg::CSR_CURVE_A, {32'sd411775, 32'sd327680});
      step_queue = '{32'sd8192, 32'sd30000, 32'sd40000, 32'sd65536, 32'sd1};
      drain();
      write_reg(pmc_pkg::CSR_DURATION, 64'd0);
      write_reg(pmc_pkg::CSR_CONTROL, {pmc_pkg::END_TRANSITION, 1'b0, 2'd3});
      step_queue = '{32'sd5, -32'sd5};
      drain();
      write_reg(pmc_pkg::CSR_CONTROL, {pmc_pkg::END_REMOVAL, 1'b1, pmc_pkg::MODE_ORBIT});
      write_reg(pmc_pkg::CSR_DURATION, 64'h7FFFFFFF);
      write_reg(pmc_pkg::CSR_CURVE_A, {32'h7FFFFFFF, 32'h80000000});
      step_queue = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd7};
      drain();

      // Receiver holds off for a long stretch so the block backs up.
      stall_hold = 400;
      for (int i = 0; i < 10; i++) step_queue.push_back(random_step(m_duration));
      drain();

      // Random phases with fresh settings.
      for (int p = 0; p < 22; p++) begin
         write_reg(pmc_pkg::CSR_CONTROL, 64'($urandom_range(0, 31)));
         write_reg(pmc_pkg::CSR_DURATION, 64'(random_duration()));
         write_reg(pmc_pkg::CSR_START, random_pair());
         write_reg(pmc_pkg::CSR_CURVE_A, random_pair());
         write_reg(pmc_pkg::CSR_CURVE_B, random_pair());
         write_reg(pmc_pkg::CSR_ROTATION, random_pair());
         for (int i = 0; i < 24; i++) step_queue.push_back(random_step(m_duration));
         drain();
      end
      stimulus_done = 1;
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("procedural_motion_curve_step_tb: done, clean");
      end else begin
         $display("procedural_motion_curve_step_tb: done, errors");
      end
      $finish;
   end

endmodule
